// ===== rtl/led_enc_pkg.sv =====
// ----------------------------------------------------------------------------
// led_enc_pkg
// Shared types and constants of the addressable LED bit encoder.
// ----------------------------------------------------------------------------
package led_enc_pkg;

   localparam int TimeW  = 10;
   localparam int GapW   = 16;
   localparam int CountW = 11;
   localparam int ByteW  = 8;

   localparam logic [TimeW-1:0] TIMER_MAX = 10'h3FF;

   // register map, index = byte address / 4
   localparam logic [2:0] REG_HIGH_ZERO = 3'd0;
   localparam logic [2:0] REG_HIGH_ONE  = 3'd1;
   localparam logic [2:0] REG_PERIOD    = 3'd2;
   localparam logic [2:0] REG_GAP       = 3'd3;
   localparam logic [2:0] REG_LED_COUNT = 3'd4;

   localparam logic [TimeW-1:0]  RST_HIGH_ZERO = 10'd24;
   localparam logic [TimeW-1:0]  RST_HIGH_ONE  = 10'd48;
   localparam logic [TimeW-1:0]  RST_PERIOD    = 10'd100;
   localparam logic [GapW-1:0]   RST_GAP       = 16'd4000;
   localparam logic [CountW-1:0] RST_LED_COUNT = 11'd0;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_PUSH = 1'b1
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [ByteW-1:0] data;
   } word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [TimeW-1:0]  high_zero;
      logic [TimeW-1:0]  high_one;
      logic [TimeW-1:0]  period;
      logic [GapW-1:0]   gap;
      logic [CountW-1:0] led_count;
   } cfg_type;

endpackage

// ===== rtl/addressable_led_bit_encoder_core.sv =====
// ----------------------------------------------------------------------------
// addressable_led_bit_encoder_core
// Serial encoder for one addressable LED data line, driven by a word stream.
// ----------------------------------------------------------------------------
// Usage:
//   Request words carry an operation: a tick advances the bit timing by one
//   clock of the line, a push offers one color byte to the one-byte buffer.
//   Every request word yields exactly one response word with the line level,
//   buffer-empty flag, push status, frame-active flag and underrun flag.
//   A request word passes the input stage, a queue slot and the response
//   register. Throughput: one word per clock while rsp_stall is low; the
//   input stage, the queue and the bit engine each move a word every clock.
//   Stall: when rsp_stall holds the response register, the engine stops and
//   the queue fills; req_stall rises once the queue and the input stage are
//   both full. No word is lost or repeated.
//   Reset: synchronous, active high; the line is idle, the buffer empty, the
//   gap already met and the registers return to their defaults.
//   Registers sit on the APB port at byte address 4 * index and are to be
//   written only while no words are in flight.
// ----------------------------------------------------------------------------
module addressable_led_bit_encoder_core import led_enc_pkg::*; #(
   parameter int BYTES_PER_PIXEL = 3,
   parameter int MAX_LEDS        = 1024,
   parameter int QUEUE_DEPTH     = 4
) (
   input  logic             clock,
   input  logic             reset,
   // request words
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [ByteW-1:0] req_pixel_byte,
   // response words
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_line_level,
   output logic             rsp_accepts_byte,
   output logic             rsp_byte_taken,
   output logic             rsp_frame_active,
   output logic             rsp_underrun,
   // register port
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type          cfg_ff, cfg_in;
   logic             cfg_write;
   logic [2:0]       reg_index;
   queue_status_type q_status;
   logic             q_push, q_pop;
   word_type         push_word, pop_word;

   // register port: no wait states, write on the access phase
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_HIGH_ZERO: cfg_in.high_zero = csr_pwdata[TimeW-1:0];
            REG_HIGH_ONE:  cfg_in.high_one  = csr_pwdata[TimeW-1:0];
            REG_PERIOD:    cfg_in.period    = csr_pwdata[TimeW-1:0];
            REG_GAP:       cfg_in.gap       = csr_pwdata[GapW-1:0];
            REG_LED_COUNT: cfg_in.led_count = csr_pwdata[CountW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // read back: unused upper bits read as zero
   always_comb begin
      case (reg_index)
         REG_HIGH_ZERO: csr_prdata = 32'(cfg_ff.high_zero);
         REG_HIGH_ONE:  csr_prdata = 32'(cfg_ff.high_one);
         REG_PERIOD:    csr_prdata = 32'(cfg_ff.period);
         REG_GAP:       csr_prdata = 32'(cfg_ff.gap);
         REG_LED_COUNT: csr_prdata = 32'(cfg_ff.led_count);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_zero <= RST_HIGH_ZERO;
         cfg_ff.high_one  <= RST_HIGH_ONE;
         cfg_ff.period    <= RST_PERIOD;
         cfg_ff.gap       <= RST_GAP;
         cfg_ff.led_count <= RST_LED_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: take and classify request words
   led_enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_pixel_byte (req_pixel_byte),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_word         (push_word)
   );

   // decouple front and engine so each side can stall alone
   led_enc_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .pop       (q_pop),
      .pop_word  (pop_word),
      .status    (q_status)
   );

   // back: advance the line state and register the response word
   led_enc_back #(
      .BytesPerPixel (BYTES_PER_PIXEL),
      .MaxLeds       (MAX_LEDS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_status         (q_status),
      .q_word           (pop_word),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_level   (rsp_line_level),
      .rsp_accepts_byte (rsp_accepts_byte),
      .rsp_byte_taken   (rsp_byte_taken),
      .rsp_frame_active (rsp_frame_active),
      .rsp_underrun     (rsp_underrun)
   );

endmodule

// ===== rtl/led_enc_front.sv =====
// ----------------------------------------------------------------------------
// led_enc_front
// Input stage: take request words, classify them and hand them to the queue.
// ----------------------------------------------------------------------------
module led_enc_front import led_enc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [ByteW-1:0] req_pixel_byte,
   input  queue_status_type q_status,
   output logic             q_push,
   output word_type         q_word
);

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;
   logic     accept;

   assign req_stall = valid_ff & q_status.full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = valid_ff & ~q_status.full;
   assign q_word    = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (accept) begin
         valid_in     = 1'b1;
         word_in.op   = (req_operation == OP_PUSH) ? OP_PUSH : OP_TICK;
         word_in.data = req_pixel_byte;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

// ===== rtl/led_enc_queue.sv =====
// ----------------------------------------------------------------------------
// led_enc_queue
// Short FIFO between the input stage and the bit engine.
// ----------------------------------------------------------------------------
module led_enc_queue import led_enc_pkg::*; #(
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  word_type         push_word,
   input  logic             pop,
   output word_type         pop_word,
   output queue_status_type status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   word_type            slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign status.full  = (count_ff == CntW'(Depth));
   assign status.empty = (count_ff == '0);
   assign pop_word     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full && !pop |-> !push)
      else $error("queue written while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count beyond depth");

endmodule

// ===== rtl/led_enc_back.sv =====
// ----------------------------------------------------------------------------
// led_enc_back
// Bit engine: runs one word per cycle against the line state while a word
// is queued and the response register is free; registers the response word.
// ----------------------------------------------------------------------------
module led_enc_back import led_enc_pkg::*; #(
   parameter int BytesPerPixel = 3,
   parameter int MaxLeds       = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  queue_status_type q_status,
   input  word_type         q_word,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_line_level,
   output logic             rsp_accepts_byte,
   output logic             rsp_byte_taken,
   output logic             rsp_frame_active,
   output logic             rsp_underrun
);

   localparam int LedW  = $clog2(MaxLeds + 1);
   localparam int CmpW  = (LedW > CountW) ? LedW : CountW;
   localparam int ProdW = $clog2(MaxLeds * BytesPerPixel + 1);
   localparam int RemW  = (MaxLeds * BytesPerPixel > 2) ?
                          $clog2(MaxLeds * BytesPerPixel) : 1;

   logic [ByteW-1:0] shift_ff, shift_in;
   logic [3:0]       bits_left_ff, bits_left_in;
   logic [ByteW-1:0] buf_byte_ff, buf_byte_in;
   logic             buf_full_ff, buf_full_in;
   logic [RemW-1:0]  remain_ff, remain_in;
   logic [TimeW-1:0] timer_ff, timer_in;
   logic [TimeW-1:0] high_ff, high_in;
   logic [GapW-1:0]  gap_ff, gap_in;
   logic             sending_ff, sending_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic line_ff, accepts_ff, taken_ff, active_ff, under_ff;
   logic taken, under;

   logic [CmpW-1:0]  count_ext, max_ext, leds_cmp;
   logic [LedW-1:0]  leds;
   logic [ProdW-1:0] frame_bytes;
   logic [GapW-1:0]  gap_dec;
   logic [TimeW-1:0] t_next;
   logic             last_bit;

   assign q_pop = ~q_status.empty & (~rsp_valid_ff | ~rsp_stall);

   assign count_ext   = CmpW'(cfg.led_count);
   assign max_ext     = CmpW'(MaxLeds);
   assign leds_cmp    = (count_ext > max_ext) ? max_ext : count_ext;
   assign leds        = LedW'(leds_cmp);
   assign frame_bytes = ProdW'(leds) * ProdW'(BytesPerPixel);
   assign gap_dec     = (gap_ff != '0) ? gap_ff - 1'b1 : gap_ff;
   assign t_next      = (timer_ff != TIMER_MAX) ? timer_ff + 1'b1 : timer_ff;
   assign last_bit    = (bits_left_ff == '0) && (remain_ff == '0);

   always_comb begin
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      buf_byte_in  = buf_byte_ff;
      buf_full_in  = buf_full_ff;
      remain_in    = remain_ff;
      timer_in     = timer_ff;
      high_in      = high_ff;
      gap_in       = gap_ff;
      sending_in   = sending_ff;
      taken        = 1'b0;
      under        = 1'b0;
      if (q_word.op == OP_PUSH) begin
         if (!buf_full_ff) begin
            buf_byte_in = q_word.data;
            buf_full_in = 1'b1;
            taken       = 1'b1;
         end
      end else if (!sending_ff) begin
         gap_in = gap_dec;
         if (gap_dec == '0 && leds != '0 && buf_full_ff) begin
            // frame start: load buffer and start its first bit
            buf_full_in  = 1'b0;
            remain_in    = RemW'(frame_bytes - 1'b1);
            sending_in   = 1'b1;
            high_in      = buf_byte_ff[ByteW-1] ? cfg.high_one : cfg.high_zero;
            shift_in     = {buf_byte_ff[ByteW-2:0], 1'b0};
            bits_left_in = 4'd7;
            timer_in     = '0;
         end
      end else if (last_bit && t_next >= high_ff) begin
         sending_in = 1'b0;
         timer_in   = '0;
         gap_in     = cfg.gap;
      end else if (!last_bit && t_next >= cfg.period && t_next >= high_ff) begin
         if (bits_left_ff != '0) begin
            high_in      = shift_ff[ByteW-1] ? cfg.high_one : cfg.high_zero;
            shift_in     = {shift_ff[ByteW-2:0], 1'b0};
            bits_left_in = bits_left_ff - 1'b1;
            timer_in     = '0;
         end else if (buf_full_ff) begin
            buf_full_in  = 1'b0;
            remain_in    = remain_ff - 1'b1;
            high_in      = buf_byte_ff[ByteW-1] ? cfg.high_one : cfg.high_zero;
            shift_in     = {buf_byte_ff[ByteW-2:0], 1'b0};
            bits_left_in = 4'd7;
            timer_in     = '0;
         end else begin
            timer_in = t_next;
            under    = 1'b1;
         end
      end else begin
         timer_in = t_next;
      end
   end

   always_comb begin
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bits_left_ff <= '0;
         buf_byte_ff  <= '0;
         buf_full_ff  <= 1'b0;
         remain_ff    <= '0;
         timer_ff     <= '0;
         high_ff      <= '0;
         gap_ff       <= '0;
         sending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            shift_ff     <= shift_in;
            bits_left_ff <= bits_left_in;
            buf_byte_ff  <= buf_byte_in;
            buf_full_ff  <= buf_full_in;
            remain_ff    <= remain_in;
            timer_ff     <= timer_in;
            high_ff      <= high_in;
            gap_ff       <= gap_in;
            sending_ff   <= sending_in;
         end
      end
      if (q_pop) begin
         line_ff    <= sending_in & (timer_in < high_in);
         accepts_ff <= ~buf_full_in;
         taken_ff   <= taken;
         active_ff  <= sending_in;
         under_ff   <= under;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_level   = line_ff;
   assign rsp_accepts_byte = accepts_ff;
   assign rsp_byte_taken   = taken_ff;
   assign rsp_frame_active = active_ff;
   assign rsp_underrun     = under_ff;

   a_line_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && line_ff |-> active_ff)
      else $error("line high outside a frame");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> timer_ff == '0)
      else $error("bit timer running while idle");

   a_under_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && under_ff |-> !taken_ff && active_ff && !line_ff)
      else $error("underrun flagged on a push or with line high");

endmodule

// ===== bench/tb_addressable_led_bit_encoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_addressable_led_bit_encoder_core
// Self-checking bench for the addressable LED bit encoder. A bit-accurate
// encoder predictor runs on every request word the core takes, and each
// response word is checked against the oldest prediction. Directed
// sequences cover the zero count, dropped pushes, frame start and underrun.
// Randomized traffic then sweeps many timing settings, register extremes,
// timer saturation and a long response hold-off.
// ----------------------------------------------------------------------------
module tb_addressable_led_bit_encoder_core;
   import led_enc_pkg::*;

   localparam int BYTES_PER_PIXEL = 3;
   localparam int MAX_LEDS        = 1024;
   localparam int MAX_IDLE        = 6;     // per-word idle draw on each side
   localparam int SETTLE_CYCLES   = 4;     // settle time after the last response word
   localparam int HOLD_CYCLES     = 300;   // long response hold-off
   localparam int WATCHDOG_LIMIT  = 2000;  // clocks without any word moving
   localparam int MAX_REPORTS     = 10;

   // what one response word carries
   typedef struct packed {
      logic line_level;
      logic accepts_byte;
      logic byte_taken;
      logic frame_active;
      logic underrun;
   } line_status_type;

   logic             clock;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_stall;
   logic             req_operation  = OP_TICK;
   logic [ByteW-1:0] req_pixel_byte = '0;
   logic             rsp_valid;
   logic             rsp_stall      = 1'b0;
   logic             rsp_line_level;
   logic             rsp_accepts_byte;
   logic             rsp_byte_taken;
   logic             rsp_frame_active;
   logic             rsp_underrun;
   logic             csr_psel       = 1'b0;
   logic             csr_penable    = 1'b0;
   logic             csr_pwrite     = 1'b0;
   logic [4:0]       csr_paddr      = '0;
   logic [31:0]      csr_pwdata     = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   // predicted response words, oldest first
   line_status_type pending_status[$];
   int              error_count = 0;

   // pacing controls for the sender and the receiver
   bit tx_burst  = 1'b0;
   bit rx_burst  = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   // encoder predictor: register copy and line state
   cfg_type           enc_cfg = '{RST_HIGH_ZERO, RST_HIGH_ONE, RST_PERIOD,
                                  RST_GAP, RST_LED_COUNT};
   logic [ByteW-1:0]  enc_shift      = '0;
   logic [3:0]        enc_bits_left  = '0;
   logic [ByteW-1:0]  enc_buffer     = '0;
   logic              enc_buf_full   = 1'b0;
   logic [11:0]       enc_bytes_left = '0;
   logic [TimeW-1:0]  enc_bit_timer  = '0;
   logic [TimeW-1:0]  enc_high_time  = '0;
   logic [GapW-1:0]   enc_gap_timer  = '0;
   logic              enc_sending    = 1'b0;

   addressable_led_bit_encoder_core #(
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
      .MAX_LEDS        (MAX_LEDS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_pixel_byte   (req_pixel_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_level   (rsp_line_level),
      .rsp_accepts_byte (rsp_accepts_byte),
      .rsp_byte_taken   (rsp_byte_taken),
      .rsp_frame_active (rsp_frame_active),
      .rsp_underrun     (rsp_underrun),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // move the buffered byte into the shifter
   function automatic void load_byte();
      enc_shift     = enc_buffer;
      enc_buf_full  = 1'b0;
      enc_bits_left = 4'd8;
   endfunction

   // latch the high time from the MSB, then advance the shifter
   function automatic void start_bit();
      enc_high_time = enc_shift[ByteW-1] ? enc_cfg.high_one : enc_cfg.high_zero;
      enc_shift     = enc_shift << 1;
      enc_bits_left = enc_bits_left - 4'd1;
      enc_bit_timer = '0;
   endfunction

   // apply one request word to the predictor and return the status it yields
   function automatic line_status_type advance_encoder(input op_type op,
                                                       input logic [ByteW-1:0] data);
      line_status_type  status;
      logic [TimeW-1:0] next_timer;
      logic             last_bit;
      int               leds;
      status = '0;
      if (op == OP_PUSH) begin
         // a push into a full buffer is dropped
         if (!enc_buf_full) begin
            enc_buffer        = data;
            enc_buf_full      = 1'b1;
            status.byte_taken = 1'b1;
         end
      end else if (!enc_sending) begin
         // idle: count down the gap, then start once a byte is waiting
         if (enc_gap_timer != '0) enc_gap_timer = enc_gap_timer - 1'b1;
         leds = (enc_cfg.led_count > MAX_LEDS) ? MAX_LEDS : int'(enc_cfg.led_count);
         if (enc_gap_timer == '0 && leds != 0 && enc_buf_full) begin
            load_byte();
            enc_bytes_left = 12'(leds * BYTES_PER_PIXEL - 1);
            enc_sending    = 1'b1;
            start_bit();
         end
      end else begin
         next_timer = (enc_bit_timer < TIMER_MAX) ? enc_bit_timer + 1'b1 : TIMER_MAX;
         last_bit   = (enc_bits_left == '0) && (enc_bytes_left == '0);
         if (last_bit && next_timer >= enc_high_time) begin
            // frame ends with the high time of its last bit
            enc_sending   = 1'b0;
            enc_bit_timer = '0;
            enc_gap_timer = enc_cfg.gap;
         end else if (!last_bit && next_timer >= enc_cfg.period &&
                      next_timer >= enc_high_time) begin
            if (enc_bits_left != '0) begin
               start_bit();
            end else if (enc_buf_full) begin
               load_byte();
               enc_bytes_left = enc_bytes_left - 1'b1;
               start_bit();
            end else begin
               // hold the line low until a byte shows up
               enc_bit_timer   = next_timer;
               status.underrun = 1'b1;
            end
         end else begin
            enc_bit_timer = next_timer;
         end
      end
      status.line_level   = enc_sending && (enc_bit_timer < enc_high_time);
      status.accepts_byte = !enc_buf_full;
      status.frame_active = enc_sending;
      return status;
   endfunction

   // ------------------------------------------------------------------------
   // Monitors
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", what);
   endtask

   // predict on every request word the core takes
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_status.push_back(advance_encoder(op_type'(req_operation),
                                                  req_pixel_byte));
   end

   // check every response word against the oldest prediction
   always @(posedge clock) begin : status_checker
      line_status_type got;
      line_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_line_level, rsp_accepts_byte, rsp_byte_taken,
                 rsp_frame_active, rsp_underrun};
         if (pending_status.size() == 0) begin
            report_mismatch($sformatf(
               "unexpected response word: line=%b empty=%b taken=%b active=%b under=%b",
               got.line_level, got.accepts_byte, got.byte_taken,
               got.frame_active, got.underrun));
         end else begin
            want = pending_status.pop_front();
            if (got !== want)
               report_mismatch($sformatf({"status mismatch: line %b/%b empty %b/%b ",
                  "taken %b/%b active %b/%b under %b/%b (exp/act)"},
                  want.line_level, got.line_level, want.accepts_byte, got.accepts_byte,
                  want.byte_taken, got.byte_taken, want.frame_active, got.frame_active,
                  want.underrun, got.underrun));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stall after each word, plus the long hold-off
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         // hold the response side so the queue fills and req_stall rises
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_stall) begin
         if (stall_left > 0) stall_left = stall_left - 1;
         else rsp_stall <= 1'b0;
      end else if (!reset && rsp_valid) begin
         // a word moves at this edge; draw the stall before the next one
         stall_left = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left = stall_left - 1;
         end
      end
   end

   // end the run if nothing moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // offer one request word and hold it until the core takes it
   task automatic send_word(input op_type op, input logic [ByteW-1:0] data);
      int idle_cycles;
      idle_cycles = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (idle_cycles > 0) begin
         req_valid <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_pixel_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and wait until every predicted word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the predictor record the last word taken before looking
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write, then read the register back
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      logic [31:0] stored;
      case (index)
         REG_HIGH_ZERO: begin
            enc_cfg.high_zero = value[TimeW-1:0];
            stored = 32'(enc_cfg.high_zero);
         end
         REG_HIGH_ONE: begin
            enc_cfg.high_one = value[TimeW-1:0];
            stored = 32'(enc_cfg.high_one);
         end
         REG_PERIOD: begin
            enc_cfg.period = value[TimeW-1:0];
            stored = 32'(enc_cfg.period);
         end
         REG_GAP: begin
            enc_cfg.gap = value[GapW-1:0];
            stored = 32'(enc_cfg.gap);
         end
         REG_LED_COUNT: begin
            enc_cfg.led_count = value[CountW-1:0];
            stored = 32'(enc_cfg.led_count);
         end
         default: stored = '0;
      endcase
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      // keep psel high: this is the setup cycle of the read-back
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== stored)
         report_mismatch($sformatf("register %0d read back %h, expected %h",
                                   index, csr_prdata, stored));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(input int high_zero, input int high_one, input int period,
                             input int gap, input int led_count);
      csr_write(REG_HIGH_ZERO, 32'(high_zero));
      csr_write(REG_HIGH_ONE,  32'(high_one));
      csr_write(REG_PERIOD,    32'(period));
      csr_write(REG_GAP,       32'(gap));
      csr_write(REG_LED_COUNT, 32'(led_count));
   endtask

   // Random traffic. Keep the buffer fed with feed_pct odds when it is empty,
   // and throw in pushes against a full buffer with noise_pct odds.
   task automatic run_traffic(input int count, input int feed_pct, input int noise_pct,
                              input bit vary_pace);
      bit push;
      for (int i = 0; i < count; i++) begin
         if (vary_pace && (i % 50 == 0)) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
         end
         if (enc_buf_full) push = ($urandom_range(0, 99) < noise_pct);
         else push = ($urandom_range(0, 99) < feed_pct);
         send_word(push ? OP_PUSH : OP_TICK, ByteW'($urandom_range(0, 255)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // zero count: nothing goes out and the buffered byte stays put
   task automatic test_zero_count();
      csr_write(REG_LED_COUNT, 32'd0);
      send_word(OP_PUSH, 8'hFF);
      send_word(OP_PUSH, 8'h00);   // buffer full, dropped
      repeat (3) send_word(OP_TICK, 8'h5A);
      send_word(OP_PUSH, 8'hA5);   // still full
      wait_drained();
   endtask

   // frame starts on the first tick, then the byte runs out mid-frame
   task automatic test_frame_start_underrun();
      set_timing(1, 1, 1, 0, 1);
      send_word(OP_TICK, 8'h00);             // line high in this same word
      repeat (7) send_word(OP_TICK, 8'hFF);
      repeat (3) send_word(OP_TICK, 8'h00);  // boundary with empty buffer
      send_word(OP_PUSH, 8'h00);
      repeat (2) send_word(OP_TICK, 8'h00);
      wait_drained();
   endtask

   task automatic test_frame_stream();
      int period;
      repeat (4) begin
         period = $urandom_range(1, 12);
         set_timing($urandom_range(0, period), $urandom_range(1, period), period,
                    $urandom_range(0, 40), $urandom_range(1, 3));
         run_traffic(60, 90, 5, 1'b1);
         wait_drained();
      end
   endtask

   // high time at or past the period: the next bit starts as the line falls
   task automatic test_long_high_time();
      int period;
      repeat (2) begin
         period = $urandom_range(1, 5);
         set_timing($urandom_range(period, period + 10), $urandom_range(period, period + 10),
                    period, $urandom_range(0, 10), $urandom_range(1, 2));
         run_traffic(70, 90, 5, 1'b1);
         wait_drained();
      end
   endtask

   // zero gap: back-to-back frames
   task automatic test_zero_gap();
      set_timing($urandom_range(1, 2), $urandom_range(2, 4), 4, 0, 1);
      run_traffic(100, 95, 5, 1'b1);
      wait_drained();
   endtask

   // starve the buffer so most boundaries find no byte
   task automatic test_underrun();
      set_timing(1, 2, 3, 5, 2);
      run_traffic(100, 15, 20, 1'b1);
      wait_drained();
   endtask

   // hold the response side while the sender keeps offering words
   task automatic test_backpressure();
      rx_burst  = 1'b0;
      tx_burst  = 1'b1;
      hold_left = HOLD_CYCLES;
      run_traffic(80, 90, 5, 1'b0);
      tx_burst = 1'b0;
      wait_drained();
   endtask

   // a long underrun drives the bit timer into saturation
   task automatic test_timer_saturation();
      set_timing(1, 1, 1, 0, 1);
      run_traffic(40, 90, 0, 1'b1);
      run_traffic(1060, 0, 0, 1'b1);
      run_traffic(20, 90, 5, 1'b1);
      wait_drained();
   endtask

   // count past the LED limit and the widest gap; this frame never finishes
   task automatic test_count_cap();
      int period;
      period = $urandom_range(1, 4);
      set_timing($urandom_range(1, period), $urandom_range(1, period), period, 65535, 2047);
      run_traffic(100, 90, 5, 1'b1);
      wait_drained();
   endtask

   // widest times, run inside the capped frame
   task automatic test_slow_bits();
      set_timing(1023, 1023, 1023, 65535, 2047);
      run_traffic(80, 90, 5, 1'b1);
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_count();
      test_frame_start_underrun();
      test_frame_stream();
      test_long_high_time();
      test_zero_gap();
      test_underrun();
      test_backpressure();
      test_timer_saturation();
      test_count_cap();
      test_slow_bits();
      if (error_count == 0 && pending_status.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
